>>> sv/b2da_pkg.sv
`default_nettype none

package b2da_pkg;

    localparam int VALUE_W       = 32;
    localparam int NATIVE_DIGITS = 10;
    localparam int MAX_DIGITS    = 10;
    localparam int CAP_DIGITS    = (MAX_DIGITS > NATIVE_DIGITS) ? NATIVE_DIGITS : MAX_DIGITS;
    localparam int IDX_W         = $clog2(NATIVE_DIGITS);
    localparam int BIT_CNT_W     = $clog2(VALUE_W);
    localparam int CHAR_W        = 6;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_PREP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic start;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic bit_last;
        logic idx_zero;
    } dp_status_t;

endpackage

`default_nettype wire

>>> sv/binary_to_decimal_ascii_core.sv
// The first digit word is valid once the input word is accepted and the 32-step
// shift-and-add-3 loop, then ST_PREP, have run. Each further digit word follows
// in the cycle after the previous one is taken, one digit per cycle while m_ready
// is high; no new value is accepted until the last digit is taken.
// Reset: synchronous active-low aresetn returns the controller to idle.
`default_nettype none

module binary_to_decimal_ascii_core (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  [b2da_pkg::VALUE_W-1:0]        s_value,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [b2da_pkg::CHAR_W-1:0]         m_digit_char,
    output logic                                m_last_digit
);

    b2da_pkg::dp_cmd_t    cmd;
    b2da_pkg::dp_status_t status;

    b2da_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    b2da_datapath u_datapath (
        .aclk         (aclk),
        .s_value      (s_value),
        .cmd          (cmd),
        .status       (status),
        .m_digit_char (m_digit_char),
        .m_last_digit (m_last_digit)
    );

`ifndef ASSERT_OFF
    a_no_accept_while_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while digits pending");

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_digit) |=> (s_ready && !m_valid))
        else $error("not idle after last digit");

    a_accept_no_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!m_valid && !s_ready))
        else $error("output right after accept");

    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_digit_char >= 6'd48 && m_digit_char <= 6'd57))
        else $error("digit char out of range");
`endif

endmodule

`default_nettype wire

>>> sv/b2da_ctrl.sv
`default_nettype none

module b2da_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire                  m_ready,
    input  b2da_pkg::dp_status_t status,
    output b2da_pkg::dp_cmd_t    cmd
);

    b2da_pkg::state_t state_reg;
    b2da_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= b2da_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            b2da_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = b2da_pkg::ST_CONVERT;
                end
            end
            b2da_pkg::ST_CONVERT: begin
                cmd.shift = 1'b1;
                if (status.bit_last) begin
                    state_next = b2da_pkg::ST_PREP;
                end
            end
            b2da_pkg::ST_PREP: begin
                cmd.start  = 1'b1;
                state_next = b2da_pkg::ST_EMIT;
            end
            b2da_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.idx_zero) begin
                        state_next = b2da_pkg::ST_IDLE;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                state_next = b2da_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/b2da_datapath.sv
`default_nettype none

module b2da_datapath (
    input  wire                                 aclk,
    input  wire  [b2da_pkg::VALUE_W-1:0]        s_value,
    input  b2da_pkg::dp_cmd_t                   cmd,
    output b2da_pkg::dp_status_t                status,
    output logic [b2da_pkg::CHAR_W-1:0]         m_digit_char,
    output logic                                m_last_digit
);

    logic [b2da_pkg::VALUE_W-1:0]   value_reg;
    logic [3:0]                     bcd_reg [b2da_pkg::NATIVE_DIGITS];
    logic [3:0]                     adj [b2da_pkg::NATIVE_DIGITS];
    logic [3:0]                     bcd_next [b2da_pkg::NATIVE_DIGITS];
    logic [b2da_pkg::BIT_CNT_W-1:0] bit_cnt_reg;
    logic [b2da_pkg::IDX_W-1:0]     idx_reg;
    logic [b2da_pkg::IDX_W-1:0]     msd;
    logic [b2da_pkg::IDX_W-1:0]     start_idx;

    // add-3 correction, then shift one bit in
    always_comb begin
        for (int i = 0; i < b2da_pkg::NATIVE_DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
        bcd_next[0] = {adj[0][2:0], value_reg[b2da_pkg::VALUE_W-1]};
        for (int i = 1; i < b2da_pkg::NATIVE_DIGITS; i++) begin
            bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
        end
    end

    // highest nonzero digit, clipped to the buffer size
    always_comb begin
        msd = '0;
        for (int i = 0; i < b2da_pkg::NATIVE_DIGITS; i++) begin
            if (bcd_reg[i] != 4'd0) begin
                msd = b2da_pkg::IDX_W'(i);
            end
        end
        if (msd > b2da_pkg::IDX_W'(b2da_pkg::CAP_DIGITS - 1)) begin
            start_idx = b2da_pkg::IDX_W'(b2da_pkg::CAP_DIGITS - 1);
        end else begin
            start_idx = msd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg   <= s_value;
            bit_cnt_reg <= '0;
            for (int i = 0; i < b2da_pkg::NATIVE_DIGITS; i++) begin
                bcd_reg[i] <= 4'd0;
            end
        end else if (cmd.shift) begin
            value_reg   <= {value_reg[b2da_pkg::VALUE_W-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg + 1'b1;
            for (int i = 0; i < b2da_pkg::NATIVE_DIGITS; i++) begin
                bcd_reg[i] <= bcd_next[i];
            end
        end
        if (cmd.start) begin
            idx_reg <= start_idx;
        end else if (cmd.step) begin
            idx_reg <= idx_reg - 1'b1;
        end
    end

    assign status.bit_last = (bit_cnt_reg == b2da_pkg::BIT_CNT_W'(b2da_pkg::VALUE_W - 1));
    assign status.idx_zero = (idx_reg == '0);

    assign m_digit_char = b2da_pkg::ASCII_ZERO + {2'b00, bcd_reg[idx_reg]};
    assign m_last_digit = status.idx_zero;

endmodule

`default_nettype wire
